// File: hw/rtl/ggpc_pkg.sv
// shared constants, types and helper functions of the go-to-goal pose controller
// used by ggpc_cordic and go_to_goal_pose_controller; depends on nothing else
package ggpc_pkg;

    localparam int POS_WIDTH_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 14;

    localparam int ANG_W  = 15;   // q3.12 angle and rate fields
    localparam int ERR_W  = 18;   // heading error before wrapping
    localparam int ZW     = 21;   // cordic angle, radians * 65536
    localparam int LIN_W  = 14;

    localparam logic signed [ZW-1:0]    PI_Q16     = 21'sd205887;
    localparam logic [15:0]             INV_K_Q16  = 16'd39797;
    localparam logic signed [ERR_W-1:0] PI_Q12     = 18'sd12868;
    localparam logic signed [ERR_W-1:0] TWO_PI_Q12 = 18'sd25736;
    localparam logic [LIN_W-1:0]        VMAX_Q12   = 14'd8192;
    localparam logic signed [ERR_W-1:0] PSI_OK_Q12 = 18'sd1024;
    localparam logic signed [ERR_W-1:0] EPS_TH_Q12 = 18'sd82;
    localparam int                      EPS_POS_Q10 = 51;

    localparam logic REQ_POSE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic start;
        logic vec_mode;   // 1 vectoring (atan2, magnitude), 0 rotation (cos)
    } cordic_ctl_t;

    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        logic [16:0] a;
        case (i)
            5'd0:  a = 17'd51472;
            5'd1:  a = 17'd30385;
            5'd2:  a = 17'd16055;
            5'd3:  a = 17'd8150;
            5'd4:  a = 17'd4091;
            5'd5:  a = 17'd2047;
            5'd6:  a = 17'd1024;
            5'd7:  a = 17'd512;
            5'd8:  a = 17'd256;
            5'd9:  a = 17'd128;
            5'd10: a = 17'd64;
            5'd11: a = 17'd32;
            5'd12: a = 17'd16;
            5'd13: a = 17'd8;
            5'd14: a = 17'd4;
            5'd15: a = 17'd2;
            5'd16: a = 17'd1;
            default: a = 17'd0;
        endcase
        return a;
    endfunction

    // error magnitudes here never need more than two turns either way
    function automatic logic signed [ERR_W-1:0] wrap_err(input logic signed [ERR_W-1:0] e);
        logic signed [ERR_W-1:0] r;
        r = e;
        if (r > PI_Q12) r = r - TWO_PI_Q12;
        if (r > PI_Q12) r = r - TWO_PI_Q12;
        if (r <= -PI_Q12) r = r + TWO_PI_Q12;
        if (r <= -PI_Q12) r = r + TWO_PI_Q12;
        return r;
    endfunction

    function automatic logic signed [ANG_W-1:0] clamp_rate(input logic signed [20:0] v);
        logic signed [ANG_W-1:0] r;
        if (v > 21'sd8192)       r = 15'sd8192;
        else if (v < -21'sd8192) r = -15'sd8192;
        else                     r = v[ANG_W-1:0];
        return r;
    endfunction

endpackage

// File: hw/rtl/go_to_goal_pose_controller.sv
// go-to-goal unicycle controller top level: handshakes, stage sequencer, output register
// depends on ggpc_pkg and ggpc_cordic
//
// Pose items (tuser 0) store x, y and heading. Tick items (tuser 1) give one command item
// once a pose is known: in the go-to-point stage a vectoring cordic run gives distance and
// bearing, and while the bearing error is small a second cordic run gives its cosine. Align
// and done ticks go straight to the emit state. The single cordic unit serves both runs;
// s_tready stays low while a tick is in work. The command waits in an output register until
// taken.
module go_to_goal_pose_controller #(
    parameter int POS_WIDTH    = ggpc_pkg::POS_WIDTH_DEF,
    parameter int CORDIC_STEPS = ggpc_pkg::CORDIC_STEPS_DEF,
    localparam int IN_BITS = 2 * POS_WIDTH + ggpc_pkg::ANG_W,
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
    localparam int CFG_W   = (POS_WIDTH > ggpc_pkg::ANG_W) ? POS_WIDTH : ggpc_pkg::ANG_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // pose_x_in, pose_y_in, pose_heading_in, zero pad
    input  logic             s_tuser,   // req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // linear_cmd, angular_cmd, stage_out, done_flag
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int CW = POS_WIDTH + 18;
    localparam int ZW = ggpc_pkg::ZW;
    localparam int MW = CW - 9;       // magnitude after the shift by 8, sign dropped
    localparam int DW = CW - 15;      // distance in q.10
    localparam int EW = ggpc_pkg::ERR_W;

    localparam logic [1:0] CFG_GOAL_X  = 2'd0;
    localparam logic [1:0] CFG_GOAL_Y  = 2'd1;
    localparam logic [1:0] CFG_GOAL_HD = 2'd2;

    localparam logic [1:0] STAGE_GO    = 2'd0;
    localparam logic [1:0] STAGE_ALIGN = 2'd1;
    localparam logic [1:0] STAGE_DONE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_VEC, ST_DIST, ST_HEAD, ST_COS, ST_EMIT
    } state_t;

    state_t state_reg;

    logic signed [POS_WIDTH-1:0]        goal_x_reg, goal_y_reg, pose_x_reg, pose_y_reg;
    logic signed [ggpc_pkg::ANG_W-1:0]  goal_hd_reg, pose_hd_reg;
    logic                               pose_known_reg, finished_reg;
    logic [1:0]                         stage_reg;

    logic [MW-1:0]                      mag_reg;
    logic signed [ZW-1:0]               psi_reg;
    logic [DW-1:0]                      dist_reg;
    logic [ggpc_pkg::LIN_W-1:0]         linb_reg;

    logic [ggpc_pkg::LIN_W-1:0]         res_lin_reg;
    logic signed [ggpc_pkg::ANG_W-1:0]  res_ang_reg;

    logic                               m_valid_reg;
    logic [31:0]                        m_data_reg;

    ggpc_pkg::cordic_ctl_t              cctl_reg;
    logic signed [CW-1:0]               cx_reg, cy_reg;
    logic signed [ZW-1:0]               cz_reg;
    logic                               c_done;
    logic signed [CW-1:0]               c_x;
    logic signed [ZW-1:0]               c_z;

    // datapath around the sequencer
    logic signed [POS_WIDTH:0]          dx, dy;
    logic signed [EW-1:0]               e_al, e_go;
    logic signed [ZW-1:0]               psi_rnd;
    logic [CW+6:0]                      dist_prod;
    logic [DW+2:0]                      six_dist;
    logic [16:0]                        cos_cl;
    logic [30:0]                        lin_prod;
    logic                               s_acc;

    assign s_acc = s_tvalid && s_tready;

    always_comb begin
        dx      = (POS_WIDTH+1)'(goal_x_reg) - (POS_WIDTH+1)'(pose_x_reg);
        dy      = (POS_WIDTH+1)'(goal_y_reg) - (POS_WIDTH+1)'(pose_y_reg);
        e_al    = ggpc_pkg::wrap_err(EW'(goal_hd_reg) - EW'(pose_hd_reg));
        psi_rnd = (psi_reg + ZW'(8)) >>> 4;
        e_go    = ggpc_pkg::wrap_err(EW'(psi_rnd) - EW'(pose_hd_reg));
        dist_prod = (CW+7)'(mag_reg) * (CW+7)'(ggpc_pkg::INV_K_Q16);
        six_dist  = (DW+3)'(dist_reg) * (DW+3)'(6);
        // cosine clamped to 0..1.0 in q.16
        if (c_x[CW-1])                   cos_cl = 17'd0;
        else if (c_x > CW'(65536))       cos_cl = 17'd65536;
        else                             cos_cl = c_x[16:0];
        lin_prod = 31'(linb_reg) * 31'(cos_cl);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            goal_hd_reg    <= '0;
            pose_x_reg     <= '0;
            pose_y_reg     <= '0;
            pose_hd_reg    <= '0;
            pose_known_reg <= 1'b0;
            finished_reg   <= 1'b0;
            stage_reg      <= STAGE_GO;
            m_valid_reg    <= 1'b0;
            cctl_reg       <= '0;
        end else begin
            // start is a single-cycle pulse, dropped once the cordic has taken it
            if (state_reg == ST_VEC || state_reg == ST_COS) cctl_reg.start <= 1'b0;
            if (m_valid_reg && m_tready && state_reg != ST_EMIT) m_valid_reg <= 1'b0;

            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_GOAL_X:  goal_x_reg  <= POS_WIDTH'(cfg_data);
                    CFG_GOAL_Y:  goal_y_reg  <= POS_WIDTH'(cfg_data);
                    CFG_GOAL_HD: goal_hd_reg <= cfg_data[ggpc_pkg::ANG_W-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        if (s_tuser == ggpc_pkg::REQ_POSE) begin
                            pose_x_reg     <= s_tdata[POS_WIDTH-1:0];
                            pose_y_reg     <= s_tdata[2*POS_WIDTH-1:POS_WIDTH];
                            pose_hd_reg    <= s_tdata[IN_BITS-1:2*POS_WIDTH];
                            pose_known_reg <= 1'b1;
                        end else if (pose_known_reg) begin
                            res_lin_reg <= '0;
                            res_ang_reg <= '0;
                            if (stage_reg == STAGE_GO) begin
                                // vectoring run on the goal offset, scaled up by 2^14
                                cx_reg   <= CW'(dx) <<< 14;
                                cy_reg   <= CW'(dy) <<< 14;
                                cz_reg   <= '0;
                                cctl_reg <= '{start: 1'b1, vec_mode: 1'b1};
                                state_reg <= ST_VEC;
                            end else if (stage_reg == STAGE_ALIGN) begin
                                if (e_al <= ggpc_pkg::EPS_TH_Q12 && e_al >= -ggpc_pkg::EPS_TH_Q12)
                                    stage_reg <= STAGE_DONE;
                                else
                                    res_ang_reg <= ggpc_pkg::clamp_rate(21'(e_al) * 21'sd4);
                                state_reg <= ST_EMIT;
                            end else begin
                                // done stage, and the unused stage code acts the same
                                finished_reg <= 1'b1;
                                state_reg    <= ST_EMIT;
                            end
                        end
                    end
                end
                ST_VEC: begin
                    if (c_done) begin
                        mag_reg   <= c_x[CW-2:8];
                        psi_reg   <= c_z;
                        state_reg <= ST_DIST;
                    end
                end
                ST_DIST: begin
                    dist_reg  <= dist_prod[CW+6:22];
                    state_reg <= ST_HEAD;
                end
                ST_HEAD: begin
                    if (dist_reg <= DW'(ggpc_pkg::EPS_POS_Q10)) begin
                        stage_reg <= STAGE_ALIGN;
                        state_reg <= ST_EMIT;
                    end else begin
                        res_ang_reg <= ggpc_pkg::clamp_rate(21'(e_go) * 21'sd6);
                        if (e_go < ggpc_pkg::PSI_OK_Q12 && e_go > -ggpc_pkg::PSI_OK_Q12) begin
                            if (dist_reg > DW'(8192) || six_dist > (DW+3)'(8192))
                                linb_reg <= ggpc_pkg::VMAX_Q12;
                            else
                                linb_reg <= six_dist[ggpc_pkg::LIN_W-1:0];
                            // rotation run for cos of the bearing error
                            cx_reg   <= CW'(ggpc_pkg::INV_K_Q16);
                            cy_reg   <= '0;
                            cz_reg   <= ZW'(e_go) <<< 4;
                            cctl_reg <= '{start: 1'b1, vec_mode: 1'b0};
                            state_reg <= ST_COS;
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_COS: begin
                    if (c_done) begin
                        res_lin_reg <= lin_prod[29:16];
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {finished_reg, stage_reg, res_ang_reg, res_lin_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    ggpc_cordic #(
        .POS_WIDTH    (POS_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cctl_reg),
        .x_in    (cx_reg),
        .y_in    (cy_reg),
        .z_in    (cz_reg),
        .done    (c_done),
        .x_out   (c_x),
        .z_out   (c_z)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

endmodule

// File: hw/rtl/ggpc_cordic.sv
// shared iterative cordic: vectoring for atan2 and magnitude, rotation for cos
// one micro-rotation per cycle; depends on ggpc_pkg
module ggpc_cordic #(
    parameter int POS_WIDTH    = ggpc_pkg::POS_WIDTH_DEF,
    parameter int CORDIC_STEPS = ggpc_pkg::CORDIC_STEPS_DEF,
    localparam int CW = POS_WIDTH + 18,
    localparam int NW = $clog2(CORDIC_STEPS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ggpc_pkg::cordic_ctl_t         ctl,
    input  logic signed [CW-1:0]          x_in,
    input  logic signed [CW-1:0]          y_in,
    input  logic signed [ggpc_pkg::ZW-1:0] z_in,
    output logic                          done,
    output logic signed [CW-1:0]          x_out,
    output logic signed [ggpc_pkg::ZW-1:0] z_out
);

    logic signed [CW-1:0]           x_reg, y_reg;
    logic signed [ggpc_pkg::ZW-1:0] z_reg;
    logic [NW-1:0]                  cnt_reg;
    logic                           busy_reg, vec_reg, done_reg;

    logic signed [CW-1:0]           xs, ys;
    logic signed [ggpc_pkg::ZW-1:0] a;
    logic                           pos_dir;

    always_comb begin
        xs = y_reg >>> cnt_reg;
        ys = x_reg >>> cnt_reg;
        a  = $signed({{(ggpc_pkg::ZW-17){1'b0}}, ggpc_pkg::atan_q16(5'(cnt_reg))});
        // vectoring drives y to zero, rotation drives z to zero
        pos_dir = vec_reg ? !y_reg[CW-1] : z_reg[ggpc_pkg::ZW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            vec_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (ctl.start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                vec_reg  <= ctl.vec_mode;
                cnt_reg  <= '0;
                if (ctl.vec_mode && x_in[CW-1]) begin
                    x_reg <= -x_in;
                    y_reg <= -y_in;
                    z_reg <= y_in[CW-1] ? -ggpc_pkg::PI_Q16 : ggpc_pkg::PI_Q16;
                end else begin
                    x_reg <= x_in;
                    y_reg <= y_in;
                    z_reg <= z_in;
                end
            end else if (busy_reg) begin
                if (pos_dir) begin
                    x_reg <= x_reg + xs;
                    y_reg <= y_reg - ys;
                    z_reg <= z_reg + a;
                end else begin
                    x_reg <= x_reg - xs;
                    y_reg <= y_reg + ys;
                    z_reg <= z_reg - a;
                end
                done_reg <= (cnt_reg == NW'(CORDIC_STEPS - 1));
                if (cnt_reg == NW'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign z_out = z_reg;

endmodule

// File: test/go_to_goal_pose_controller_tb.sv
// self-checking testbench of the go-to-goal pose controller: directed table, then random
// phases over several goals, stages and handshake idling; depends on ggpc_pkg and the rtl
`timescale 1ns / 1ps

module go_to_goal_pose_controller_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;

    // register indexes of the goal write channel
    localparam logic [1:0] REG_GOAL_X       = 2'd0;
    localparam logic [1:0] REG_GOAL_Y       = 2'd1;
    localparam logic [1:0] REG_GOAL_HEADING = 2'd2;

    typedef enum logic [1:0] {ST_GO = 2'd0, ST_ALIGN = 2'd1, ST_DONE = 2'd2} stage_t;

    // directed rows: predicted, fixed with no command, or fixed command
    typedef enum int {ROW_PREDICT, ROW_NO_CMD, ROW_FIXED} row_kind_t;

    // packed from the top bit down, so linear_cmd sits in the lowest bits
    typedef struct packed {
        logic               dn;
        logic [1:0]         stg;
        logic signed [14:0] ang;
        logic [13:0]        lin;
    } cmd_t;

    typedef struct {
        logic               rt;
        int                 x;
        int                 y;
        int                 h;
        row_kind_t          kind;
        cmd_t               cmd;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // pose_x_in, pose_y_in, pose_heading_in, zero pad
    logic        s_tuser = 1'b0; // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // linear_cmd, angular_cmd, stage_out, done_flag
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    always #5 aclk = ~aclk;

    go_to_goal_pose_controller i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // controller copy kept by the testbench
    longint goal_x_q, goal_y_q, goal_hd_q;
    longint pose_x_q, pose_y_q, pose_hd_q;
    bit     pose_seen, reached;
    stage_t stage_q;

    cmd_t   cmd_queue[$];
    int     n_errors = 0;
    int     send_pct = 0;
    int     recv_pct = 0;
    bit     hold_req = 0;
    int     hold_left = 0;

    const longint ATAN_Q16[14] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                   256, 128, 64, 32, 16, 8};

    // floor shift, the same as an arithmetic right shift
    function automatic longint sra(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint wrap_angle(input longint e);
        while (e > 12868) e -= 25736;
        while (e <= -12868) e += 25736;
        return e;
    endfunction

    // vectoring pass: magnitude with cordic gain, bearing in q.16
    function automatic longint bearing_mag(input longint x, input longint y,
                                           output longint z);
        longint nx, ny;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? 205887 : -205887;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 14; i++) begin
            if (y >= 0) begin
                nx = x + sra(y, i); ny = y - sra(x, i); z += ATAN_Q16[i];
            end else begin
                nx = x - sra(y, i); ny = y + sra(x, i); z -= ATAN_Q16[i];
            end
            x = nx; y = ny;
        end
        return x;
    endfunction

    // rotation pass: cosine in q.16 of an angle in q.16
    function automatic longint cos_q16(input longint z);
        longint x, y, nx, ny;
        x = 39797;
        y = 0;
        for (int i = 0; i < 14; i++) begin
            if (z >= 0) begin
                nx = x - sra(y, i); ny = y + sra(x, i); z -= ATAN_Q16[i];
            end else begin
                nx = x + sra(y, i); ny = y - sra(x, i); z += ATAN_Q16[i];
            end
            x = nx; y = ny;
        end
        return x;
    endfunction

    // one accepted item: updates the controller copy, returns 1 when a command follows
    function automatic bit steer(input logic rt, input int x, input int y, input int h,
                                 output cmd_t c);
        longint lin, ang, dx, dy, psi, mag, rng, e, cs;
        lin = 0;
        ang = 0;
        c = '0;
        if (rt == ggpc_pkg::REQ_POSE) begin
            pose_x_q = longint'($signed(16'(x)));
            pose_y_q = longint'($signed(16'(y)));
            pose_hd_q = longint'($signed(15'(h)));
            pose_seen = 1;
            return 0;
        end
        if (!pose_seen) return 0;
        case (stage_q)
            ST_GO: begin
                dx = goal_x_q - pose_x_q;
                dy = goal_y_q - pose_y_q;
                mag = bearing_mag(dx * 16384, dy * 16384, psi);
                rng = (sra(mag, 8) * 39797) >>> 22;
                if (rng <= 51) begin
                    stage_q = ST_ALIGN;
                end else begin
                    e = wrap_angle(sra(psi + 8, 4) - pose_hd_q);
                    ang = clip(6 * e, -8192, 8192);
                    if (e < 1024 && e > -1024) begin
                        cs = clip(cos_q16(e * 16), 0, 65536);
                        lin = rng > 8192 ? 8192 : 6 * rng;
                        if (lin > 8192) lin = 8192;
                        lin = (lin * cs) >>> 16;
                        if (lin < 0) lin = 0;
                    end
                end
            end
            ST_ALIGN: begin
                e = wrap_angle(goal_hd_q - pose_hd_q);
                if (e <= 82 && e >= -82) stage_q = ST_DONE;
                else ang = clip(4 * e, -8192, 8192);
            end
            default: reached = 1;   // done, and the unused code acts the same
        endcase
        c.lin = 14'(lin);
        c.ang = 15'(ang);
        c.stg = stage_q;
        c.dn = reached;
        return 1;
    endfunction

    // receiver: random stalls, plus a long hold when asked for
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= recv_pct);
        end
    end

    // command checker
    always @(posedge aclk) begin
        cmd_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (cmd_queue.size() == 0) begin
                $error("command item with none expected: %h", m_tdata);
                n_errors++;
            end else begin
                want = cmd_queue.pop_front();
                if (got.lin !== want.lin) begin
                    $error("linear_cmd: expected %0d, got %0d", want.lin, got.lin);
                    n_errors++;
                end
                if (got.ang !== want.ang) begin
                    $error("angular_cmd: expected %0d, got %0d", want.ang, got.ang);
                    n_errors++;
                end
                if (got.stg !== want.stg) begin
                    $error("stage_out: expected %0d, got %0d", want.stg, got.stg);
                    n_errors++;
                end
                if (got.dn !== want.dn) begin
                    $error("done_flag: expected %0d, got %0d", want.dn, got.dn);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[go_to_goal_pose_controller] ERROR");
            $finish;
        end
    end

    // called at a falling edge; returns at a falling edge with s_tvalid still high
    task automatic send_item(input logic rt, input int x, input int y, input int h,
                             input row_kind_t kind = ROW_PREDICT, input cmd_t fixed = '0);
        cmd_t c;
        bit   has_cmd;
        while ($urandom_range(99) < send_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = rt;
        // non-pose items carry the given data too
        s_tdata = {1'b0, 15'(h), 16'(y), 16'(x)};
        do @(posedge aclk); while (!s_tready);
        has_cmd = steer(rt, x, y, h, c);
        if (kind == ROW_FIXED) cmd_queue.push_back(fixed);
        else if (kind == ROW_PREDICT && has_cmd) cmd_queue.push_back(c);
        @(negedge aclk);
    endtask

    // sender stops and waits until every command has come back
    task automatic drain;
        s_tvalid = 1'b0;
        while (cmd_queue.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = 16'(val);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_GOAL_X:       goal_x_q = longint'($signed(16'(val)));
            REG_GOAL_Y:       goal_y_q = longint'($signed(16'(val)));
            REG_GOAL_HEADING: goal_hd_q = longint'($signed(15'(val)));
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_goal(input int gx, input int gy, input int gh);
        write_reg(REG_GOAL_X, gx);
        write_reg(REG_GOAL_Y, gy);
        write_reg(REG_GOAL_HEADING, gh);
    endtask

    function automatic void pick_idling(input int n);
        case ((n / 50) % 4)
            0: begin send_pct = 0;  recv_pct = 0;  end
            1: begin send_pct = 45; recv_pct = 0;  end
            2: begin send_pct = 0;  recv_pct = 45; end
            default: begin send_pct = 14; recv_pct = 14; end
        endcase
    endfunction

    function automatic int clip16(input int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    // random item: pose far off, pose near with a heading close to the bearing, or tick
    task automatic go_item;
        int px, py, ph, dx, dy;
        real brg;
        case ($urandom_range(9))
            0, 1: send_item(ggpc_pkg::REQ_POSE, $urandom, $urandom, $urandom_range(32767));
            2, 3: begin
                dx = $urandom_range(1900) + 80;
                dy = $urandom_range(3000);
                if ($urandom_range(1)) dx = -dx;
                if ($urandom_range(1)) dy = -dy;
                if ($urandom_range(3) == 0) begin
                    int t = dx; dx = dy; dy = t;
                end
                px = clip16(int'(goal_x_q) - dx);
                py = clip16(int'(goal_y_q) - dy);
                brg = $atan2(real'(goal_y_q - py), real'(goal_x_q - px));
                ph = int'(brg * 4096.0) + $urandom_range(3000) - 1500;
                ph = ph > 12868 ? ph - 25736 : (ph < -12868 ? ph + 25736 : ph);
                send_item(ggpc_pkg::REQ_POSE, px, py, ph);
            end
            default: send_item(ggpc_pkg::REQ_TICK, $urandom, $urandom, $urandom);
        endcase
    endtask

    stim_row_t dir_rows[$];
    int        n_item = 0;

    initial begin
        int gx, gy, gh, ph;
        goal_x_q = 0; goal_y_q = 0; goal_hd_q = 0;
        pose_x_q = 0; pose_y_q = 0; pose_hd_q = 0;
        pose_seen = 0; reached = 0; stage_q = ST_GO;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed part, goal at (1000, -1000) in q5.10
        set_goal(1000, -1000, 0);
        dir_rows = '{
            '{ggpc_pkg::REQ_TICK, 0, 0, 0, ROW_NO_CMD, '0},          // tick before any pose
            '{ggpc_pkg::REQ_POSE, -32768, 32767, -12868, ROW_NO_CMD, '0},
            '{ggpc_pkg::REQ_TICK, 0, 0, 0, ROW_PREDICT, '0},
            '{ggpc_pkg::REQ_POSE, 32767, -32768, 12868, ROW_NO_CMD, '0},
            '{ggpc_pkg::REQ_TICK, -1, -1, -1, ROW_PREDICT, '0},
            // goal straight behind, dy zero
            '{ggpc_pkg::REQ_POSE, 2000, -1000, 0, ROW_NO_CMD, '0},
            '{ggpc_pkg::REQ_TICK, 0, 0, 0, ROW_PREDICT, '0},
            // behind, dy just negative
            '{ggpc_pkg::REQ_POSE, 2000, -999, 0, ROW_NO_CMD, '0},
            '{ggpc_pkg::REQ_TICK, 0, 0, 0, ROW_PREDICT, '0},
            // on the y axis, above
            '{ggpc_pkg::REQ_POSE, 1000, -2000, 6434, ROW_NO_CMD, '0},
            '{ggpc_pkg::REQ_TICK, 0, 0, 0, ROW_PREDICT, '0},
            // on the y axis, below
            '{ggpc_pkg::REQ_POSE, 1000, 0, -6434, ROW_NO_CMD, '0},
            '{ggpc_pkg::REQ_TICK, 0, 0, 0, ROW_PREDICT, '0},
            // facing the goal, speed set by the range
            '{ggpc_pkg::REQ_POSE, 0, -1000, 0, ROW_NO_CMD, '0},
            '{ggpc_pkg::REQ_TICK, 0, 0, 0, ROW_PREDICT, '0},
            // heading beyond pi
            '{ggpc_pkg::REQ_POSE, 0, -1000, 16383, ROW_NO_CMD, '0},
            '{ggpc_pkg::REQ_TICK, 0, 0, 0, ROW_PREDICT, '0},
            '{ggpc_pkg::REQ_POSE, 0, -1000, -16384, ROW_NO_CMD, '0},
            '{ggpc_pkg::REQ_TICK, 0, 0, 0, ROW_PREDICT, '0},
            // just outside the arrival radius
            '{ggpc_pkg::REQ_POSE, 940, -1000, 0, ROW_NO_CMD, '0},
            '{ggpc_pkg::REQ_TICK, 0, 0, 0, ROW_PREDICT, '0},
            // inside the arrival radius, so the stage moves to align
            '{ggpc_pkg::REQ_POSE, 1010, -990, 900, ROW_NO_CMD, '0},
            '{ggpc_pkg::REQ_TICK, 0, 0, 0, ROW_PREDICT, '0}
        };
        foreach (dir_rows[i])
            send_item(dir_rows[i].rt, dir_rows[i].x, dir_rows[i].y, dir_rows[i].h,
                      dir_rows[i].kind, dir_rows[i].cmd);
        drain();

        // random phases over goal extremes
        for (int ph_i = 0; ph_i < 4; ph_i++) begin
            case (ph_i)
                0: set_goal(0, 0, 0);
                1: set_goal(32767, 32767, 12868);
                2: set_goal(-32768, -32768, -12868);
                default: set_goal($urandom, $urandom, $urandom_range(25736) - 12868);
            endcase
            for (int k = 0; k < 200; k++) begin
                pick_idling(n_item);
                // block fills up behind a long receiver hold
                if (ph_i == 0 && k == 20) hold_req = 1;
                go_item();
                n_item++;
            end
            drain();
        end

        // arrive at the goal, then align with a few goal headings
        send_pct = 0; recv_pct = 0;
        send_item(ggpc_pkg::REQ_POSE, int'(goal_x_q) + (goal_x_q > 0 ? -20 : 20),
                  int'(goal_y_q) + (goal_y_q > 0 ? -20 : 20), 0);
        send_item(ggpc_pkg::REQ_TICK, 0, 0, 0);
        drain();
        for (int ph_i = 0; ph_i < 3; ph_i++) begin
            gh = (ph_i == 0) ? 12868 : (ph_i == 1) ? -12868 : $urandom_range(20000) - 10000;
            write_reg(REG_GOAL_HEADING, gh);
            for (int k = 0; k < 50; k++) begin
                pick_idling(n_item);
                if ($urandom_range(1)) begin
                    // keep clear of the goal heading so the stage holds
                    ph = gh + 200 + $urandom_range(25000);
                    ph = ph > 16383 ? ph - 25736 : ph;
                    if (ph <= gh + 100 - 25736 + 25736 && ph >= gh - 100) ph = gh + 300;
                    send_item(ggpc_pkg::REQ_POSE, $urandom, $urandom, ph);
                end else begin
                    send_item(ggpc_pkg::REQ_TICK, $urandom, $urandom, $urandom);
                end
                n_item++;
            end
            drain();
        end

        // heading error exactly on the tolerance edge, then the done stage
        send_item(ggpc_pkg::REQ_POSE, 0, 0, int'(goal_hd_q) + 82);
        send_item(ggpc_pkg::REQ_TICK, 0, 0, 0);
        for (int k = 0; k < 40; k++) begin
            pick_idling(k * 13);
            send_item($urandom_range(3) != 0 ? ggpc_pkg::REQ_TICK : ggpc_pkg::REQ_POSE,
                      $urandom, $urandom, $urandom);
        end
        drain();
        repeat (50) @(negedge aclk);

        if (cmd_queue.size() != 0) begin
            $error("%0d command items never arrived", cmd_queue.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("[go_to_goal_pose_controller] OK");
        end else begin
            $display("[go_to_goal_pose_controller] ERROR");
        end
        $finish;
    end

endmodule
